// ----- design/tae_pkg.sv -----
// Shared types and constants of the tar archive entry walker.
`timescale 1ns / 1ps
package tae_pkg;

	localparam int OFFSET_WIDTH = 40;
	localparam int BLOCK_BYTES = 512;
	localparam int POS_WIDTH = $clog2(BLOCK_BYTES);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_ENTRY = 2'd0;
	localparam logic [1:0] KIND_TWO_EMPTY = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;
	localparam logic [1:0] KIND_IMAGE_END = 2'd3;

	localparam logic [1:0] CLASS_REGULAR = 2'd0;
	localparam logic [1:0] CLASS_DIRECTORY = 2'd1;
	localparam logic [1:0] CLASS_OTHER = 2'd2;

	localparam logic [31:0] COUNT_MAX = 32'h8000_0000;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [1:0]              result_kind;
		logic [7:0]              entry_type_byte;
		logic [1:0]              entry_class;
		logic [35:0]             entry_size;
		logic [23:0]             entry_mode;
		logic [OFFSET_WIDTH-1:0] data_offset;
		logic [31:0]             entry_count;
		logic [47:0]             size_total;
		logic                    last_result;
	} result_beat_t;

	// What the front hands to the back for one byte.
	typedef struct packed {
		logic                    first_valid;
		logic [1:0]              first_kind;
		logic [7:0]              type_byte;
		logic [1:0]              class_code;
		logic [35:0]             size;
		logic [23:0]             mode;
		logic [OFFSET_WIDTH-1:0] offset;
		logic                    image_end;
		logic                    restart;
	} walk_event_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_SKIP   = 3'b010,
		PH_DONE   = 3'b100
	} walk_phase_t;

endpackage

// ----- design/tae_front.sv -----
// Front part: parses header bytes, skips file data and classifies each block.
`timescale 1ns / 1ps
module tae_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  tae_pkg::byte_beat_t beat,
	output logic                push,
	output tae_pkg::walk_event_t ev
);
	import tae_pkg::*;

	walk_phase_t            phase_q, phase_d;
	logic [POS_WIDTH-1:0]   pos_q, pos_d;
	logic [36:0]            skip_q, skip_d;
	logic                   empty_seen_q, empty_seen_d;
	logic                   any_nz_q, any_nz_d;
	logic                   magic_good_q, magic_good_d;
	logic [35:0]            size_acc_q, size_acc_d;
	logic                   size_end_q, size_end_d;
	logic [23:0]            mode_acc_q, mode_acc_d;
	logic                   mode_end_q, mode_end_d;
	logic [7:0]             type_q, type_d;
	logic [OFFSET_WIDTH-1:0] offset_q, offset_d;

	logic [7:0]             b;
	logic                   oct;
	logic [36:0]            skip_dec;
	logic [36:0]            rounded;
	logic [OFFSET_WIDTH-1:0] offset_inc;

	assign b = beat.data_byte;
	assign oct = (b[7:3] == 5'b00110);
	assign offset_inc = offset_q + OFFSET_WIDTH'(1);
	assign rounded = 37'(size_acc_q) + 37'(BLOCK_BYTES - 1);
	assign skip_dec = (skip_q != 37'd0) ? skip_q - 37'd1 : skip_q;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		skip_d = skip_q;
		empty_seen_d = empty_seen_q;
		any_nz_d = any_nz_q;
		magic_good_d = magic_good_q;
		size_acc_d = size_acc_q;
		size_end_d = size_end_q;
		mode_acc_d = mode_acc_q;
		mode_end_d = mode_end_q;
		type_d = type_q;
		offset_d = offset_inc;
		ev = '0;

		unique case (phase_q)
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 37'd0) begin
					phase_d = PH_HEADER;
				end
			end
			PH_HEADER: begin
				if (b != 8'd0) begin
					any_nz_d = 1'b1;
				end
				if (pos_q >= POS_WIDTH'(100) && pos_q < POS_WIDTH'(108) && !mode_end_q) begin
					if (b == 8'd0) begin
						mode_end_d = 1'b1;
					end else if (oct) begin
						mode_acc_d = {mode_acc_q[20:0], b[2:0]};
					end
				end
				if (pos_q >= POS_WIDTH'(124) && pos_q < POS_WIDTH'(136) && !size_end_q) begin
					if (b == 8'd0) begin
						size_end_d = 1'b1;
					end else if (oct) begin
						size_acc_d = {size_acc_q[32:0], b[2:0]};
					end
				end
				if (pos_q == POS_WIDTH'(156)) begin
					type_d = b;
				end
				if ((pos_q == POS_WIDTH'(257) && b != "u") ||
				    (pos_q == POS_WIDTH'(258) && b != "s") ||
				    (pos_q == POS_WIDTH'(259) && b != "t") ||
				    (pos_q == POS_WIDTH'(260) && b != "a") ||
				    (pos_q == POS_WIDTH'(261) && b != "r") ||
				    ((pos_q == POS_WIDTH'(263) || pos_q == POS_WIDTH'(264)) && b != "0")) begin
					magic_good_d = 1'b0;
				end

				if (pos_q != POS_WIDTH'(BLOCK_BYTES - 1)) begin
					pos_d = pos_q + POS_WIDTH'(1);
				end else begin
					if (!any_nz_d) begin
						if (empty_seen_q) begin
							ev.first_valid = 1'b1;
							ev.first_kind = KIND_TWO_EMPTY;
							phase_d = PH_DONE;
						end else begin
							empty_seen_d = 1'b1;
						end
					end else begin
						empty_seen_d = 1'b0;
						if (!magic_good_q) begin
							ev.first_valid = 1'b1;
							ev.first_kind = KIND_INVALID;
							phase_d = PH_DONE;
						end else begin
							ev.first_valid = 1'b1;
							ev.first_kind = KIND_ENTRY;
							ev.type_byte = type_q;
							if (type_q == "0" || type_q == 8'd0) begin
								ev.class_code = CLASS_REGULAR;
							end else if (type_q == "5") begin
								ev.class_code = CLASS_DIRECTORY;
							end else begin
								ev.class_code = CLASS_OTHER;
							end
							ev.size = size_acc_q;
							ev.mode = mode_acc_q;
							ev.offset = offset_inc;
							skip_d = {rounded[36:POS_WIDTH], POS_WIDTH'(0)};
							phase_d = (skip_d != 37'd0) ? PH_SKIP : PH_HEADER;
						end
					end
					pos_d = '0;
					any_nz_d = 1'b0;
					magic_good_d = 1'b1;
					size_acc_d = '0;
					size_end_d = 1'b0;
					mode_acc_d = '0;
					mode_end_d = 1'b0;
					type_d = '0;
				end
			end
			default: begin
			end
		endcase

		if (beat.last_byte) begin
			ev.restart = 1'b1;
			ev.image_end = (phase_d != PH_DONE);
			phase_d = PH_HEADER;
			pos_d = '0;
			skip_d = '0;
			empty_seen_d = 1'b0;
			any_nz_d = 1'b0;
			magic_good_d = 1'b1;
			size_acc_d = '0;
			size_end_d = 1'b0;
			mode_acc_d = '0;
			mode_end_d = 1'b0;
			type_d = '0;
			offset_d = '0;
		end
	end

	assign push = accept & (ev.first_valid | beat.last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			skip_q <= '0;
			empty_seen_q <= 1'b0;
			any_nz_q <= 1'b0;
			magic_good_q <= 1'b1;
			size_acc_q <= '0;
			size_end_q <= 1'b0;
			mode_acc_q <= '0;
			mode_end_q <= 1'b0;
			type_q <= '0;
			offset_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			skip_q <= skip_d;
			empty_seen_q <= empty_seen_d;
			any_nz_q <= any_nz_d;
			magic_good_q <= magic_good_d;
			size_acc_q <= size_acc_d;
			size_end_q <= size_end_d;
			mode_acc_q <= mode_acc_d;
			mode_end_q <= mode_end_d;
			type_q <= type_d;
			offset_q <= offset_d;
		end
	end

endmodule

// ----- design/tae_queue.sv -----
// Short queue of walk events between the front and the back.
`timescale 1ns / 1ps
module tae_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tae_pkg::walk_event_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output tae_pkg::walk_event_t head
);
	import tae_pkg::*;

	walk_event_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_WIDTH-1:0]   wr_q;
	logic [QPTR_WIDTH-1:0]   rd_q;
	logic [QPTR_WIDTH:0]     count_q;

	assign full = (count_q == (QPTR_WIDTH + 1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_WIDTH'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_WIDTH'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_WIDTH + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_WIDTH + 1)'(1);
			end
		end
	end

endmodule

// ----- design/tae_back.sv -----
// Back part: keeps the running totals and builds the result beats.
`timescale 1ns / 1ps
module tae_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ev_valid,
	input  tae_pkg::walk_event_t   ev,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output tae_pkg::result_beat_t  result_beat
);
	import tae_pkg::*;

	logic [31:0]   count_q, count_d;
	logic [47:0]   sum_q, sum_d;
	logic          second_q, second_d;
	logic          out_valid_q;
	result_beat_t  out_q, rec;
	logic          load;
	logic          out_free;
	logic [31:0]   count_inc;
	logic [48:0]   sum_wide;
	logic [47:0]   sum_sat;

	assign out_free = !out_valid_q || !result_stall;
	assign count_inc = (count_q < COUNT_MAX) ? count_q + 32'd1 : count_q;
	assign sum_wide = {1'b0, sum_q} + 49'(ev.size);
	assign sum_sat = sum_wide[48] ? '1 : sum_wide[47:0];

	always_comb begin
		pop = 1'b0;
		load = 1'b0;
		rec = '0;
		count_d = count_q;
		sum_d = sum_q;
		second_d = second_q;
		rec.entry_count = count_q;
		rec.size_total = sum_q;
		if (ev_valid && out_free) begin
			if (second_q) begin
				load = 1'b1;
				rec.result_kind = KIND_IMAGE_END;
				rec.last_result = 1'b1;
				pop = 1'b1;
				second_d = 1'b0;
			end else if (ev.first_valid) begin
				load = 1'b1;
				rec.result_kind = ev.first_kind;
				rec.last_result = !ev.image_end;
				if (ev.first_kind == KIND_ENTRY) begin
					count_d = count_inc;
					sum_d = sum_sat;
					rec.entry_type_byte = ev.type_byte;
					rec.entry_class = ev.class_code;
					rec.entry_size = ev.size;
					rec.entry_mode = ev.mode;
					rec.data_offset = ev.offset;
					rec.entry_count = count_inc;
					rec.size_total = sum_sat;
				end
				if (ev.image_end) begin
					second_d = 1'b1;
				end else begin
					pop = 1'b1;
				end
			end else if (ev.image_end) begin
				load = 1'b1;
				rec.result_kind = KIND_IMAGE_END;
				rec.last_result = 1'b1;
				pop = 1'b1;
			end else begin
				pop = 1'b1;
			end
			if (pop && ev.restart) begin
				count_d = '0;
				sum_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			second_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			sum_q <= sum_d;
			second_q <= second_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= rec;
		end
	end

	assign result_valid = out_valid_q;
	assign result_beat = out_q;

endmodule

// ----- design/tar_archive_entry_walker.sv -----
// Top level of the tar archive entry walker.
// Takes one archive byte per cycle while byte_stall is low; the result is registered.
// A byte ending a valid header and the image yields an entry beat, then an end beat.
// The four-entry event queue stalls the byte side only when the result side is held.
// Reset clears walk state and totals at once; an image's last byte also clears both.
`timescale 1ns / 1ps
module tar_archive_entry_walker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  tae_pkg::byte_beat_t   byte_beat,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tae_pkg::result_beat_t result_beat
);
	import tae_pkg::*;

	logic        accept;
	logic        push;
	logic        full;
	logic        pop;
	logic        not_empty;
	walk_event_t ev_in;
	walk_event_t ev_head;

	assign byte_stall = full;
	assign accept = byte_valid & !full;

	tae_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.beat   (byte_beat),
		.push   (push),
		.ev     (ev_in)
	);

	tae_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (ev_in),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (ev_head)
	);

	tae_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (not_empty),
		.ev           (ev_head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

endmodule

// ----- tb/tar_archive_entry_walker_tb.sv -----
// Self-checking testbench for the tar archive entry walker, with a predictor and random images.
`timescale 1ns / 1ps
module tar_archive_entry_walker_tb;
	import tae_pkg::*;

	localparam logic [39:0] USTAR = "ustar";
	localparam logic [47:0] SUM_LIMIT = 48'hFFFF_FFFF_FFFF;
	localparam int RX_HOLD_CYCLES = 400;

	typedef struct {
		byte_beat_t beat;
		bit         wait_drain;
		bit         hold_rx;
	} queued_byte_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         byte_valid = 1'b0;
	logic         byte_stall;
	byte_beat_t   byte_beat = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_beat_t result_beat;

	queued_byte_t pending_bytes[$];
	result_beat_t expected_records[$];
	logic [7:0]   image_buf[$];
	int           error_count = 0;
	int           bytes_made = 0;
	int           gap_left = 0;
	int           hold_left = 0;
	bit           sender_gappy = 1'b0;
	bit           rx_choppy = 1'b0;
	logic         byte_taken = 1'b0;
	logic         hold_pulse = 1'b0;

	walk_phase_t             walk_ph;
	logic [POS_WIDTH-1:0]    blk_pos;
	logic [36:0]             skip_left;
	bit                      saw_empty;
	bit                      saw_nonzero;
	bit                      magic_ok;
	logic [35:0]             size_acc;
	bit                      size_done;
	logic [23:0]             mode_acc;
	bit                      mode_done;
	logic [7:0]              type_seen;
	logic [OFFSET_WIDTH-1:0] image_off;
	logic [31:0]             valid_headers;
	logic [47:0]             size_running;

	tar_archive_entry_walker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_beat  (result_beat)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	function automatic void clear_header_scan();
		blk_pos = '0;
		saw_nonzero = 1'b0;
		magic_ok = 1'b1;
		size_acc = '0;
		size_done = 1'b0;
		mode_acc = '0;
		mode_done = 1'b0;
		type_seen = '0;
	endfunction

	function automatic void restart_walk();
		walk_ph = PH_HEADER;
		skip_left = '0;
		saw_empty = 1'b0;
		image_off = '0;
		valid_headers = '0;
		size_running = '0;
		clear_header_scan();
	endfunction

	function automatic result_beat_t walk_record(logic [1:0] kind, logic [7:0] tflag,
			logic [1:0] cls, logic [35:0] sz, logic [23:0] md, logic [OFFSET_WIDTH-1:0] off);
		result_beat_t r;
		r.result_kind = kind;
		r.entry_type_byte = tflag;
		r.entry_class = cls;
		r.entry_size = sz;
		r.entry_mode = md;
		r.data_offset = off;
		r.entry_count = valid_headers;
		r.size_total = size_running;
		r.last_result = 1'b0;
		return r;
	endfunction

	// Advances the walk by one accepted byte and queues the records it should give.
	function automatic void walk_byte(byte_beat_t beat);
		result_beat_t recs[2];
		int n;
		logic [7:0] b;
		logic [48:0] wide_sum;
		logic [36:0] rounded;
		logic [1:0] cls;
		n = 0;
		b = beat.data_byte;
		if (walk_ph == PH_SKIP) begin
			if (skip_left != 0) skip_left = skip_left - 1;
			if (skip_left == 0) walk_ph = PH_HEADER;
		end else if (walk_ph == PH_HEADER) begin
			if (b != 0) saw_nonzero = 1'b1;
			if (blk_pos >= 100 && blk_pos < 108 && !mode_done) begin
				if (b == 0) mode_done = 1'b1;
				else if (b >= "0" && b <= "7") mode_acc = {mode_acc[20:0], b[2:0]};
			end
			if (blk_pos >= 124 && blk_pos < 136 && !size_done) begin
				if (b == 0) size_done = 1'b1;
				else if (b >= "0" && b <= "7") size_acc = {size_acc[32:0], b[2:0]};
			end
			if (blk_pos == 156) type_seen = b;
			if (blk_pos >= 257 && blk_pos < 262 && b != USTAR[8*(261-blk_pos) +: 8]) begin
				magic_ok = 1'b0;
			end
			if ((blk_pos == 263 || blk_pos == 264) && b != "0") magic_ok = 1'b0;
			if (blk_pos != POS_WIDTH'(BLOCK_BYTES - 1)) begin
				blk_pos = blk_pos + 1;
			end else begin
				if (!saw_nonzero) begin
					if (saw_empty) begin
						recs[n] = walk_record(KIND_TWO_EMPTY, '0, '0, '0, '0, '0);
						n++;
						walk_ph = PH_DONE;
					end else begin
						saw_empty = 1'b1;
					end
				end else begin
					saw_empty = 1'b0;
					if (!magic_ok) begin
						recs[n] = walk_record(KIND_INVALID, '0, '0, '0, '0, '0);
						n++;
						walk_ph = PH_DONE;
					end else begin
						if (type_seen == "0" || type_seen == 0) cls = CLASS_REGULAR;
						else if (type_seen == "5") cls = CLASS_DIRECTORY;
						else cls = CLASS_OTHER;
						if (valid_headers < COUNT_MAX) valid_headers = valid_headers + 1;
						wide_sum = {1'b0, size_running} + size_acc;
						size_running = (wide_sum > SUM_LIMIT) ? SUM_LIMIT : wide_sum[47:0];
						recs[n] = walk_record(KIND_ENTRY, type_seen, cls, size_acc, mode_acc,
							image_off + 1);
						n++;
						rounded = ({1'b0, size_acc} + 37'd511) & ~37'd511;
						skip_left = rounded;
						walk_ph = (rounded != 0) ? PH_SKIP : PH_HEADER;
					end
				end
				clear_header_scan();
			end
		end
		image_off = image_off + 1;
		if (beat.last_byte) begin
			if (walk_ph != PH_DONE) begin
				recs[n] = walk_record(KIND_IMAGE_END, '0, '0, '0, '0, '0);
				n++;
			end
			restart_walk();
		end
		for (int i = 0; i < n; i++) begin
			recs[i].last_result = (i == n - 1);
			expected_records.push_back(recs[i]);
		end
	endfunction

	function automatic void add_fill(int count, bit zeros);
		for (int i = 0; i < count; i++) begin
			image_buf.push_back(zeros ? 8'h00 : 8'($urandom));
		end
	endfunction

	// A fault of 1 to 5 spoils one magic letter, 6 or 7 one version digit.
	function automatic void add_header(logic [7:0] tflag, string size_txt, string mode_txt,
			int fault, bit noisy);
		logic [7:0] blk[BLOCK_BYTES];
		int at;
		for (int i = 0; i < BLOCK_BYTES; i++) blk[i] = noisy ? 8'($urandom) : 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (i < mode_txt.len()) blk[100+i] = mode_txt[i];
			else if (i == mode_txt.len()) blk[100+i] = 8'h00;
		end
		for (int i = 0; i < 12; i++) begin
			if (i < size_txt.len()) blk[124+i] = size_txt[i];
			else if (i == size_txt.len()) blk[124+i] = 8'h00;
		end
		blk[156] = tflag;
		for (int i = 0; i < 5; i++) blk[257+i] = USTAR[8*(4-i) +: 8];
		blk[263] = "0";
		blk[264] = "0";
		if (fault != 0) begin
			at = (fault <= 5) ? 256 + fault : 257 + fault;
			blk[at] = blk[at] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < BLOCK_BYTES; i++) image_buf.push_back(blk[i]);
	endfunction

	function automatic string size_text(int sz);
		case ($urandom_range(0, 3))
			0: return $sformatf("%011o", sz);
			1: return $sformatf("%o", sz);
			2: return $sformatf(" 9%o8", sz);
			default: return $sformatf("%012o", sz);
		endcase
	endfunction

	function automatic string mode_text();
		case ($urandom_range(0, 3))
			0: return $sformatf("%07o", $urandom_range(0, 4095));
			1: return $sformatf("%08o", $urandom & 32'h00FF_FFFF);
			2: return "";
			default: return $sformatf("x%o", $urandom_range(0, 511));
		endcase
	endfunction

	function automatic void close_image(bit wait_drain, bit hold_rx);
		queued_byte_t q;
		for (int i = 0; i < image_buf.size(); i++) begin
			q.beat.data_byte = image_buf[i];
			q.beat.last_byte = (i == image_buf.size() - 1);
			q.wait_drain = wait_drain && i == 0;
			q.hold_rx = hold_rx && i == 0;
			pending_bytes.push_back(q);
		end
		bytes_made += image_buf.size();
		image_buf.delete();
	endfunction

	function automatic logic [7:0] pick_type();
		case ($urandom_range(0, 3))
			0: return "0";
			1: return 8'h00;
			2: return "5";
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void build_stimulus();
		image_buf.push_back(8'h00);
		close_image(1'b0, 1'b0);
		// One full block: an entry ended by the last byte, an entry whose data runs past
		// the end, a spoilt header followed by ignored bytes, or an empty block.
		case ($urandom_range(0, 3))
			0: add_header(pick_type(), size_text($urandom_range(0, 1500)), mode_text(), 0,
				1'b1);
			1: begin
				add_header(pick_type(), size_text($urandom_range(1, 1500)), mode_text(), 0,
					1'b1);
				add_fill($urandom_range(1, 20), 1'b0);
			end
			2: begin
				add_header(pick_type(), size_text($urandom_range(0, 900)), mode_text(),
					$urandom_range(1, 7), 1'b1);
				add_fill($urandom_range(1, 20), 1'b0);
			end
			default: begin
				add_fill(BLOCK_BYTES, 1'b1);
				add_fill($urandom_range(1, 20), 1'b0);
			end
		endcase
		close_image(1'b0, 1'b0);
		// One-byte images while the receiver holds off, so the event queue fills.
		for (int k = 0; k < 16; k++) begin
			add_fill(1, 1'b0);
			close_image(k == 0, k == 0);
		end
		while (bytes_made < 850) begin
			add_fill($urandom_range(1, 40), $urandom_range(0, 3) == 0);
			close_image($urandom_range(0, 7) == 0, 1'b0);
		end
	endfunction

	function automatic int draw_gap();
		int roll;
		if ($urandom_range(0, 63) == 0) sender_gappy = !sender_gappy;
		if (!sender_gappy) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin : drive
		queued_byte_t nxt;
		logic pulse;
		pulse = 1'b0;
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || byte_taken) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				byte_valid <= 1'b0;
			end else if (pending_bytes.size() != 0 &&
					!(pending_bytes[0].wait_drain && expected_records.size() != 0)) begin
				nxt = pending_bytes.pop_front();
				byte_beat <= nxt.beat;
				byte_valid <= 1'b1;
				pulse = nxt.hold_rx;
				gap_left <= draw_gap();
			end else begin
				byte_valid <= 1'b0;
			end
		end
		hold_pulse <= pulse;
	end

	always @(negedge clk) begin : receive
		int roll;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_pulse) begin
			hold_left <= RX_HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			if ($urandom_range(0, 199) == 0) rx_choppy = !rx_choppy;
			roll = $urandom_range(0, 99);
			if (rx_choppy && roll < 25) begin
				hold_left <= $urandom_range(0, 3);
				result_stall <= 1'b1;
			end else if (rx_choppy && roll == 99) begin
				hold_left <= $urandom_range(20, 80);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch
		result_beat_t want;
		byte_taken <= arst_n && byte_valid && !byte_stall;
		if (arst_n) begin
			if (byte_valid && !byte_stall) walk_byte(byte_beat);
			if (result_valid && !result_stall) begin
				if (expected_records.size() == 0) begin
					report_mismatch("result beat arrived with nothing expected");
				end else begin
					want = expected_records.pop_front();
					check_field("result_kind", result_beat.result_kind, want.result_kind);
					check_field("entry_type_byte", result_beat.entry_type_byte,
						want.entry_type_byte);
					check_field("entry_class", result_beat.entry_class, want.entry_class);
					check_field("entry_size", result_beat.entry_size, want.entry_size);
					check_field("entry_mode", result_beat.entry_mode, want.entry_mode);
					check_field("data_offset", result_beat.data_offset, want.data_offset);
					check_field("entry_count", result_beat.entry_count, want.entry_count);
					check_field("size_total", result_beat.size_total, want.size_total);
					check_field("last_result", result_beat.last_result, want.last_result);
				end
			end
		end
	end

	initial begin
		restart_walk();
		build_stimulus();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_bytes.size() != 0 || byte_valid) @(posedge clk);
		while (expected_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_records.size() != 0) begin
			report_mismatch($sformatf("%0d expected result beats never arrived",
				expected_records.size()));
		end
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
